// ===== rtl/pdci_pkg.sv =====
// Shared constants, item types and sequencer states of the phosphor density colour index.
package pdci_pkg;

  // Fixed field widths
  localparam int HITS_W     = 32;
  localparam int IDX_OUT_W  = 8;
  localparam int DENS_OUT_W = 17;

  // Average is multiplied by this before it divides a density
  localparam int AVG_FACTOR = 3;

  // Requests held between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // Parameter defaults
  localparam int PALETTE_SIZE_DEF = 256;
  localparam int MAX_CELLS_DEF    = 1048576;
  localparam int FRAC_BITS_DEF    = 16;

  typedef enum logic [1:0] {
    CLS_EMPTY,
    CLS_SATURATE,
    CLS_DIVIDE
  } cell_class_t;

  typedef struct packed {
    logic [HITS_W-1:0] hits;
    logic [HITS_W-1:0] total;
    logic              frame_end;
    cell_class_t       cls;
  } cell_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DENS,
    ST_NORM_SETUP,
    ST_NORM,
    ST_SCALE,
    ST_STATS,
    ST_AVG,
    ST_EMIT
  } back_state_t;

endpackage

// ===== rtl/pdci_front.sv =====
// Front end: accepts cell requests, classifies them and queues them for the back end.
module pdci_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [pdci_pkg::HITS_W-1:0]      cell_hits,
  input  logic [pdci_pkg::HITS_W-1:0]      column_total,
  input  logic                             frame_end,
  output logic                             item_valid,
  output pdci_pkg::cell_item_t             item,
  input  logic                             item_take
);

  localparam int PTR_W  = (pdci_pkg::QUEUE_DEPTH > 1) ? $clog2(pdci_pkg::QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(pdci_pkg::QUEUE_DEPTH + 1);

  pdci_pkg::cell_item_t entries [pdci_pkg::QUEUE_DEPTH];
  pdci_pkg::cell_item_t new_item;
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [FILL_W-1:0]    fill;
  logic                 do_push;
  logic                 do_pop;

  // Classify: no division for an empty cell or one that saturates at one
  always_comb begin
    new_item.hits      = cell_hits;
    new_item.total     = column_total;
    new_item.frame_end = frame_end;
    if (column_total == '0 || cell_hits == '0) begin
      new_item.cls = pdci_pkg::CLS_EMPTY;
    end else if (cell_hits >= column_total) begin
      new_item.cls = pdci_pkg::CLS_SATURATE;
    end else begin
      new_item.cls = pdci_pkg::CLS_DIVIDE;
    end
  end

  assign full       = (fill == FILL_W'(pdci_pkg::QUEUE_DEPTH));
  assign item_valid = (fill != '0);
  assign item       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pdci_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pdci_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pdci_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module pdci_divider #(
  parameter int DIV_W = 32,
  parameter int Q_W   = 37,
  parameter int ST_W  = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] rem_init,
  input  logic [Q_W-1:0]   num,
  input  logic [DIV_W-1:0] den,
  input  logic [ST_W-1:0]  steps,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  logic             busy;
  logic [ST_W-1:0]  cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den_q;
  logic [Q_W-1:0]   q;
  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign r2       = {rem, q[Q_W-1]};
  assign ge       = (r2 >= {1'b0, den_q});
  assign diff     = r2 - {1'b0, den_q};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      q     <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
      q   <= {q[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == ST_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ===== rtl/pdci_back.sv =====
// Back end: density, normalization, palette scaling and frame statistics.
module pdci_back #(
  parameter int PALETTE_SIZE      = pdci_pkg::PALETTE_SIZE_DEF,
  parameter int MAX_CELLS         = pdci_pkg::MAX_CELLS_DEF,
  parameter int DENSITY_FRAC_BITS = pdci_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  pdci_pkg::cell_item_t                item,
  output logic                                item_take,
  input  logic                                pop,
  output logic                                out_valid,
  output logic [pdci_pkg::IDX_OUT_W-1:0]      palette_index,
  output logic                                empty_cell,
  output logic                                frame_done,
  output logic                                average_changed,
  output logic [pdci_pkg::DENS_OUT_W-1:0]     peak_density,
  output logic [pdci_pkg::DENS_OUT_W-1:0]     mean_density
);

  localparam int F      = DENSITY_FRAC_BITS;
  localparam int D_W    = F + 1;
  localparam int DIVR_W = D_W + $clog2(pdci_pkg::AVG_FACTOR);
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam int SUM_W  = CNT_W + F;
  localparam int DIV_A  = (pdci_pkg::HITS_W > DIVR_W) ? pdci_pkg::HITS_W : DIVR_W;
  localparam int DIV_W  = (DIV_A > CNT_W) ? DIV_A : CNT_W;
  localparam int Q_W    = SUM_W;
  localparam int ST_W   = $clog2(Q_W + 1);
  localparam int IDX_W  = $clog2(PALETTE_SIZE);
  localparam int PROD_W = D_W + IDX_W;
  localparam logic [D_W-1:0]   ONE     = {1'b1, {F{1'b0}}};
  localparam logic [IDX_W-1:0] PAL_MAX = IDX_W'(PALETTE_SIZE - 1);

  pdci_pkg::back_state_t state;
  pdci_pkg::back_state_t state_next;
  pdci_pkg::cell_item_t  cur;

  logic [D_W-1:0]    density;
  logic [D_W-1:0]    norm;
  logic [IDX_W-1:0]  index;
  logic [D_W-1:0]    avg;
  logic [D_W-1:0]    peak;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [D_W-1:0]    peak_out;
  logic              changed;

  logic [DIVR_W-1:0] avg_x3;
  logic              norm_sat;
  logic [PROD_W-1:0] prod;
  logic [IDX_W:0]    idx_raw;
  logic [IDX_W-1:0]  idx_clamped;
  logic              nonzero;
  logic              room;
  logic [D_W-1:0]    peak_new;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  count_new;
  logic              out_free;

  logic              div_start;
  logic [DIV_W-1:0]  div_rem;
  logic [Q_W-1:0]    div_num;
  logic [DIV_W-1:0]  div_den;
  logic [ST_W-1:0]   div_steps;
  logic              div_done;
  logic [Q_W-1:0]    div_q;

  logic [pdci_pkg::IDX_OUT_W+IDX_W-1:0]  idx_wide;
  logic [pdci_pkg::DENS_OUT_W+D_W-1:0]   peak_wide;
  logic [pdci_pkg::DENS_OUT_W+D_W-1:0]   avg_wide;

  pdci_divider #(
    .DIV_W (DIV_W),
    .Q_W   (Q_W),
    .ST_W  (ST_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .num      (div_num),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  assign avg_x3   = DIVR_W'(avg) * DIVR_W'(pdci_pkg::AVG_FACTOR);
  assign norm_sat = (DIVR_W'(density) >= avg_x3);

  assign prod        = PROD_W'(norm) * PROD_W'(PALETTE_SIZE - 1);
  assign idx_raw     = prod[PROD_W-1:F];
  assign idx_clamped = (idx_raw > {1'b0, PAL_MAX}) ? PAL_MAX : idx_raw[IDX_W-1:0];

  assign nonzero   = (density != '0);
  assign room      = (count < CNT_W'(MAX_CELLS));
  assign peak_new  = (nonzero && density > peak) ? density : peak;
  assign sum_new   = (nonzero && room) ? sum + SUM_W'(density) : sum;
  assign count_new = (nonzero && room) ? count + 1'b1 : count;

  assign out_free = !out_valid || pop;

  assign idx_wide  = {{pdci_pkg::IDX_OUT_W{1'b0}}, index};
  assign peak_wide = {{pdci_pkg::DENS_OUT_W{1'b0}}, peak_out};
  assign avg_wide  = {{pdci_pkg::DENS_OUT_W{1'b0}}, avg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdci_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_take  = 1'b0;
    div_start  = 1'b0;
    div_rem    = DIV_W'(item.hits);
    div_num    = '0;
    div_den    = DIV_W'(item.total);
    div_steps  = ST_W'(F);
    unique case (state)
      pdci_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          unique case (item.cls)
            pdci_pkg::CLS_DIVIDE: begin
              div_start  = 1'b1;
              state_next = pdci_pkg::ST_DENS;
            end
            pdci_pkg::CLS_SATURATE: state_next = pdci_pkg::ST_NORM_SETUP;
            default:                state_next = pdci_pkg::ST_STATS;
          endcase
        end
      end
      pdci_pkg::ST_DENS: begin
        if (div_done) begin
          state_next = pdci_pkg::ST_NORM_SETUP;
        end
      end
      pdci_pkg::ST_NORM_SETUP: begin
        div_rem = DIV_W'(density);
        div_den = DIV_W'(avg_x3);
        if (!nonzero) begin
          state_next = pdci_pkg::ST_STATS;
        end else if (norm_sat) begin
          state_next = pdci_pkg::ST_SCALE;
        end else begin
          div_start  = 1'b1;
          state_next = pdci_pkg::ST_NORM;
        end
      end
      pdci_pkg::ST_NORM: begin
        if (div_done) begin
          state_next = pdci_pkg::ST_SCALE;
        end
      end
      pdci_pkg::ST_SCALE: state_next = pdci_pkg::ST_STATS;
      pdci_pkg::ST_STATS: begin
        div_rem   = '0;
        div_num   = sum_new;
        div_den   = DIV_W'(count_new);
        div_steps = ST_W'(Q_W);
        if (cur.frame_end && count_new != '0) begin
          div_start  = 1'b1;
          state_next = pdci_pkg::ST_AVG;
        end else begin
          state_next = pdci_pkg::ST_EMIT;
        end
      end
      pdci_pkg::ST_AVG: begin
        if (div_done) begin
          state_next = pdci_pkg::ST_EMIT;
        end
      end
      pdci_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = pdci_pkg::ST_IDLE;
        end
      end
      default: state_next = pdci_pkg::ST_IDLE;
    endcase
  end

  // Frame statistics and stored average
  always_ff @(posedge clk) begin
    if (rst) begin
      avg   <= '0;
      peak  <= '0;
      sum   <= '0;
      count <= '0;
    end else begin
      if (state == pdci_pkg::ST_STATS) begin
        if (cur.frame_end) begin
          peak  <= '0;
          sum   <= '0;
          count <= '0;
        end else begin
          peak  <= peak_new;
          sum   <= sum_new;
          count <= count_new;
        end
      end
      if (state == pdci_pkg::ST_AVG && div_done) begin
        avg <= div_q[D_W-1:0];
      end
    end
  end

  // Working registers of the current cell
  always_ff @(posedge clk) begin
    case (state)
      pdci_pkg::ST_IDLE: begin
        if (item_valid) begin
          cur     <= item;
          density <= (item.cls == pdci_pkg::CLS_SATURATE) ? ONE : '0;
          index   <= '0;
          changed <= 1'b0;
        end
      end
      pdci_pkg::ST_DENS: begin
        if (div_done) begin
          density <= {1'b0, div_q[F-1:0]};
        end
      end
      pdci_pkg::ST_NORM_SETUP: begin
        if (norm_sat) begin
          norm <= ONE;
        end
      end
      pdci_pkg::ST_NORM: begin
        if (div_done) begin
          norm <= {1'b0, div_q[F-1:0]};
        end
      end
      pdci_pkg::ST_SCALE: index <= idx_clamped;
      pdci_pkg::ST_STATS: peak_out <= peak_new;
      pdci_pkg::ST_AVG: begin
        if (div_done) begin
          changed <= (div_q[D_W-1:0] != avg);
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == pdci_pkg::ST_EMIT && out_free) begin
      palette_index   <= idx_wide[pdci_pkg::IDX_OUT_W-1:0];
      empty_cell      <= !nonzero;
      frame_done      <= cur.frame_end;
      average_changed <= changed;
      peak_density    <= peak_wide[pdci_pkg::DENS_OUT_W-1:0];
      mean_density    <= avg_wide[pdci_pkg::DENS_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pdci_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == pdci_pkg::ST_DENS || state == pdci_pkg::ST_NORM ||
                  state == pdci_pkg::ST_AVG))
    else $error("divider finished outside a wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CELLS))
    else $error("cell count passed its limit");

  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    avg <= ONE)
    else $error("stored average above one");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == pdci_pkg::ST_EMIT && out_free) |=> (out_valid && state == pdci_pkg::ST_IDLE))
    else $error("result not loaded on emit");

endmodule

// ===== rtl/phosphor_density_colour_index.sv =====
// Top level of the phosphor density colour index: front queue and back-end sequencer.
//
// Usage:
//   Input channel is a queue write side: drive cell_hits, column_total and frame_end
//   and raise push; the request is taken at a clock edge where push is high and full
//   is low. Up to two requests wait in the front queue while the back end works.
//   Result channel is a queue read side: while empty is low the oldest result sits
//   on palette_index .. mean_density; pop at an edge with empty low takes it.
//   One result comes out for every request, in order.
// Sequencing:
//   The back end runs one cell at a time through a shared one-bit-per-cycle divider:
//   up to a density and a normalization division per cell, no division for an empty
//   cell and no density division for a saturated one, plus the average division on
//   the last cell of a frame.
// Reset:
//   rst (synchronous) empties both queues and clears the stored average and the
//   frame peak, sum and count to zero.
// Stall:
//   If pop stays low the finished result is held; the back end finishes the next
//   cell and holds it until the result slot frees, and full rises once the front
//   queue fills.
module phosphor_density_colour_index #(
  parameter int PALETTE_SIZE      = pdci_pkg::PALETTE_SIZE_DEF,
  parameter int MAX_CELLS         = pdci_pkg::MAX_CELLS_DEF,
  parameter int DENSITY_FRAC_BITS = pdci_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [pdci_pkg::HITS_W-1:0]      cell_hits,
  input  logic [pdci_pkg::HITS_W-1:0]      column_total,
  input  logic                             frame_end,
  output logic                             empty,
  input  logic                             pop,
  output logic [pdci_pkg::IDX_OUT_W-1:0]   palette_index,
  output logic                             empty_cell,
  output logic                             frame_done,
  output logic                             average_changed,
  output logic [pdci_pkg::DENS_OUT_W-1:0]  peak_density,
  output logic [pdci_pkg::DENS_OUT_W-1:0]  mean_density
);

  logic                 item_valid;
  logic                 item_take;
  pdci_pkg::cell_item_t item;
  logic                 out_valid;

  // Classify and hold incoming requests
  pdci_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cell_hits    (cell_hits),
    .column_total (column_total),
    .frame_end    (frame_end),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  // Compute density, palette index and frame statistics, then hold the result
  pdci_back #(
    .PALETTE_SIZE      (PALETTE_SIZE),
    .MAX_CELLS         (MAX_CELLS),
    .DENSITY_FRAC_BITS (DENSITY_FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item            (item),
    .item_take       (item_take),
    .pop             (pop),
    .out_valid       (out_valid),
    .palette_index   (palette_index),
    .empty_cell      (empty_cell),
    .frame_done      (frame_done),
    .average_changed (average_changed),
    .peak_density    (peak_density),
    .mean_density    (mean_density)
  );

  assign empty = !out_valid;

endmodule
